/* hw/rtl/vtt_pkg.sv */
// Package for the versioned type table: action and status codes, entry and transaction types.
// No dependencies.
`timescale 1ns / 1ps
package vtt_pkg;
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_FIND  = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_OVERLAP   = 3'd3,
		ST_FULL      = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	localparam int unsigned EntryW = 96;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] type_code;
		logic [31:0] schema_code;
		logic [15:0] version_low;
		logic [15:0] version_high;
		logic [15:0] query_version;
		logic [7:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  slot;
		logic [31:0] out_type_code;
		logic [31:0] out_schema_code;
		logic [15:0] out_version_low;
		logic [15:0] out_version_high;
		logic [8:0]  entry_count;
	} rsp_t;
endpackage

/* hw/rtl/vtt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module vtt_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/versioned_type_table.sv */
// Versioned type table top level: sequencer around one entry RAM.
// Depends on vtt_pkg and vtt_ram.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | req_t
//  rsp     | out       | rsp_valid/ready   | rsp_t
//
// Clear goes straight to the result; read fetches one entry; find scans to a hit.
// Add scans the whole table and, if accepted, shifts entries up one slot from
// the end down to the insertion slot, a read and a write state per moved entry.
// The single RAM port pair sets this pacing. Reset clears state, count and rsp_valid.
// A new transaction is taken in idle once the result register is empty or being taken.
`timescale 1ns / 1ps
module versioned_type_table
	import vtt_pkg::*;
#(
	parameter int unsigned CAPACITY = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_SHRD  = 6'b000100,
		S_SHWR  = 6'b001000,
		S_READ  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    pos_q;
	logic             pos_found_q;
	logic             dup_q;
	logic             ovl_q;
	logic             hit_q;
	logic             rd_pend_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [EntryW-1:0] wdata;
	logic [EntryW-1:0] rdata;

	vtt_ram #(.WIDTH(EntryW), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic [63:0] new_key, e_key;
	logic [31:0] new_rng, e_rng;
	logic [15:0] e_lo, e_hi;
	logic        e_ge, e_same;
	logic        out_free;

	assign new_key  = {req_q.type_code, req_q.schema_code};
	assign new_rng  = {req_q.version_low, req_q.version_high};
	assign e_key    = rdata[95:32];
	assign e_rng    = rdata[31:0];
	assign e_lo     = rdata[31:16];
	assign e_hi     = rdata[15:0];
	assign e_same   = (e_key == new_key);
	assign e_ge     = (e_key > new_key) || (e_same && e_rng >= new_rng);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;

	// Read address: the scan index during scan/read, the entry below during shifts.
	always_comb begin
		raddr = idx_q[AW-1:0];
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		if (state_q == S_SHRD) begin
			raddr = AW'(idx_q - CW'(1));
		end
		if (state_q == S_SHWR) begin
			we = 1'b1;
			if (idx_q == pos_q) begin
				wdata = {new_key, new_rng};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_q       <= req;
						idx_q       <= '0;
						pos_found_q <= 1'b0;
						dup_q       <= 1'b0;
						ovl_q       <= 1'b0;
						hit_q       <= 1'b0;
						rd_pend_q   <= 1'b0;
						if (req.action == ACT_READ) begin
							idx_q   <= CW'(req.slot_index);
							state_q <= S_READ;
						end else if (req.action == ACT_CLEAR ||
							(req.action == ACT_ADD && req.version_low > req.version_high)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// rd_pend_q marks that rdata holds entry idx_q-1.
					if (rd_pend_q) begin
						if (req_q.action == ACT_FIND) begin
							if (e_same && req_q.query_version >= e_lo &&
								req_q.query_version <= e_hi) begin
								hit_q   <= 1'b1;
								pos_q   <= idx_q - CW'(1);
								rsp_q.out_type_code    <= e_key[63:32];
								rsp_q.out_schema_code  <= e_key[31:0];
								rsp_q.out_version_low  <= e_lo;
								rsp_q.out_version_high <= e_hi;
								state_q <= S_DONE;
							end
						end else begin
							if (!pos_found_q && e_ge) begin
								pos_found_q <= 1'b1;
								pos_q       <= idx_q - CW'(1);
								if (e_same && e_rng == new_rng) begin
									dup_q <= 1'b1;
								end
							end
							if (e_same && !(e_lo > req_q.version_high ||
								req_q.version_low > e_hi)) begin
								ovl_q <= 1'b1;
							end
						end
					end
					if (state_q == S_SCAN && !(rd_pend_q && req_q.action == ACT_FIND &&
						e_same && req_q.query_version >= e_lo &&
						req_q.query_version <= e_hi)) begin
						if (idx_q >= count_q) begin
							if (rd_pend_q || count_q == '0) begin
								rd_pend_q <= 1'b0;
								if (req_q.action == ACT_ADD) begin
									if (!pos_found_q && !(rd_pend_q && e_ge)) begin
										pos_q <= count_q;
									end
									state_q <= S_DONE;
									idx_q   <= count_q;
								end else begin
									state_q <= S_DONE;
								end
							end
						end else begin
							rd_pend_q <= 1'b1;
							idx_q     <= idx_q + CW'(1);
						end
						if (idx_q >= count_q && rd_pend_q && req_q.action == ACT_ADD) begin
							state_q <= S_DONE;
						end
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					if (idx_q == pos_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
						rd_pend_q <= 1'b1;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= (idx_q - CW'(1) == pos_q) ? S_SHWR : S_SHRD;
					end
				end
				S_READ: begin
					if (rd_pend_q) begin
						rsp_q.out_type_code    <= e_key[63:32];
						rsp_q.out_schema_code  <= e_key[31:0];
						rsp_q.out_version_low  <= e_lo;
						rsp_q.out_version_high <= e_hi;
						state_q <= S_DONE;
					end
					rd_pend_q <= 1'b1;
				end
				S_DONE: begin
					if (req_q.action == ACT_ADD && !rd_pend_q &&
						!dup_q && !ovl_q && count_q < CW'(CAPACITY) &&
						req_q.version_low <= req_q.version_high) begin
						// Start the shift; idx_q holds count.
						state_q <= (idx_q == pos_q) ? S_SHWR : S_SHRD;
					end else if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						rsp_q.slot  <= '0;
						rsp_q.status <= ST_OK;
						rsp_q.entry_count <= 9'(count_q);
						case (action_t'(req_q.action))
							ACT_CLEAR: begin
								count_q <= '0;
								rsp_q.entry_count <= '0;
							end
							ACT_ADD: begin
								if (req_q.version_low > req_q.version_high) begin
									rsp_q.status <= ST_EMPTY;
								end else if (dup_q) begin
									rsp_q.status <= ST_DUPLICATE;
								end else if (ovl_q) begin
									rsp_q.status <= ST_OVERLAP;
								end else if (!rd_pend_q) begin
									rsp_q.status <= ST_FULL;
								end else begin
									rsp_q.slot <= 8'(pos_q);
								end
							end
							ACT_FIND: begin
								if (hit_q) begin
									rsp_q.slot <= 8'(pos_q);
								end else begin
									rsp_q.status <= ST_NOT_FOUND;
								end
							end
							ACT_READ: begin
								if (32'(req_q.slot_index) < 32'(count_q)) begin
									rsp_q.slot <= req_q.slot_index;
								end else begin
									rsp_q.status <= ST_NOT_FOUND;
								end
							end
							default: begin
								rsp_q.status <= ST_NOT_FOUND;
							end
						endcase
						if (!(req_q.action == ACT_FIND && hit_q) &&
							!(req_q.action == ACT_READ &&
							32'(req_q.slot_index) < 32'(count_q)))
						begin
							rsp_q.out_type_code    <= '0;
							rsp_q.out_schema_code  <= '0;
							rsp_q.out_version_low  <= '0;
							rsp_q.out_version_high <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(rsp))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_SHWR))
		else $error("RAM written outside shift");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHWR || state_q == S_SHRD) |-> (idx_q >= pos_q))
		else $error("shift passed insertion slot");
endmodule

/* dv/tb_versioned_type_table.sv */
// Testbench for the versioned type table: directed rows, then random add/find/read/clear traffic.
// Results are checked against a sorted-table predictor kept in the bench; depends on vtt_pkg.
`timescale 1ns / 1ps
module tb_versioned_type_table;
	import vtt_pkg::*;

	localparam int unsigned CAP = 256;
	localparam int unsigned N_RANDOM = 1490;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned REQ_W = $bits(req_t);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	versioned_type_table #(.CAPACITY(CAP)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	typedef struct {
		req_t r;
		logic check_fixed;
		rsp_t fixed;
	} row_t;

	logic [63:0] tbl_key [CAP];
	logic [31:0] tbl_rng [CAP];
	int unsigned tbl_count;
	rsp_t pending_rsp[$];
	logic [63:0] used_keys[$];
	int unsigned errors;
	int unsigned idle_cycles = 0;
	logic quiet_mode;
	logic long_hold;

	function automatic rsp_t table_apply(req_t r);
		rsp_t o;
		logic [63:0] k;
		logic [31:0] g;
		int unsigned pos;
		o = '0;
		k = {r.type_code, r.schema_code};
		g = {r.version_low, r.version_high};
		case (action_t'(r.action))
			ACT_CLEAR: begin
				tbl_count = 0;
			end
			ACT_ADD: begin
				pos = tbl_count;
				for (int i = tbl_count - 1; i >= 0; i--)
					if (tbl_key[i] > k || (tbl_key[i] == k && tbl_rng[i] >= g))
						pos = i;
				if (r.version_low > r.version_high)
					o.status = ST_EMPTY;
				else if (pos < tbl_count && tbl_key[pos] == k && tbl_rng[pos] == g)
					o.status = ST_DUPLICATE;
				else begin
					for (int i = 0; i < tbl_count; i++)
						if (tbl_key[i] == k && !(tbl_rng[i][31:16] > r.version_high ||
								r.version_low > tbl_rng[i][15:0]))
							o.status = ST_OVERLAP;
					if (o.status == ST_OK && tbl_count >= CAP)
						o.status = ST_FULL;
					if (o.status == ST_OK) begin
						for (int i = tbl_count; i > pos; i--) begin
							tbl_key[i] = tbl_key[i-1];
							tbl_rng[i] = tbl_rng[i-1];
						end
						tbl_key[pos] = k;
						tbl_rng[pos] = g;
						tbl_count++;
						o.slot = pos[7:0];
					end
				end
			end
			ACT_FIND: begin
				o.status = ST_NOT_FOUND;
				for (int i = tbl_count - 1; i >= 0; i--)
					if (tbl_key[i] == k && r.query_version >= tbl_rng[i][31:16] &&
							r.query_version <= tbl_rng[i][15:0]) begin
						o.status = ST_OK;
						o.slot = i[7:0];
						{o.out_type_code, o.out_schema_code} = tbl_key[i];
						{o.out_version_low, o.out_version_high} = tbl_rng[i];
					end
			end
			default: begin
				if (r.slot_index < tbl_count) begin
					o.slot = r.slot_index;
					{o.out_type_code, o.out_schema_code} = tbl_key[r.slot_index];
					{o.out_version_low, o.out_version_high} = tbl_rng[r.slot_index];
				end else
					o.status = ST_NOT_FOUND;
			end
		endcase
		o.entry_count = tbl_count[8:0];
		return o;
	endfunction

	function automatic req_t mk(action_t a, logic [31:0] t, logic [31:0] s,
			logic [15:0] lo, logic [15:0] hi, logic [15:0] q, logic [7:0] idx);
		req_t r;
		r = '{a, t, s, lo, hi, q, idx};
		return r;
	endfunction

	function automatic rsp_t bare(status_t st, logic [7:0] sl, logic [8:0] cnt);
		rsp_t o;
		o = '0;
		o.status = st;
		o.slot = sl;
		o.entry_count = cnt;
		return o;
	endfunction

	function automatic req_t rand_req(int unsigned mode);
		req_t r;
		logic [63:0] k;
		int unsigned p;
		int unsigned lo;
		int unsigned span;
		r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
		if (used_keys.size() == 0 || $urandom_range(0, 9) == 0)
			used_keys.push_back({$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)});
		if (used_keys.size() > 24)
			void'(used_keys.pop_front());
		k = used_keys[$urandom_range(0, used_keys.size() - 1)];
		{r.type_code, r.schema_code} = k;
		p = $urandom_range(0, 99);
		if (mode == 1)
			r.action = (p < 85) ? ACT_ADD : ACT_READ;
		else if (p < 1)
			r.action = ACT_CLEAR;
		else if (p < 45)
			r.action = ACT_ADD;
		else if (p < 75)
			r.action = ACT_FIND;
		else
			r.action = ACT_READ;
		if ($urandom_range(0, 9) != 0) begin
			lo = $urandom_range(0, 65535);
			span = $urandom_range(0, 40);
			r.version_low = 16'(lo);
			r.version_high = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(lo, 65535)) :
				((lo + span > 65535) ? 16'hFFFF : 16'(lo + span));
			if (mode == 1) begin
				r.version_low = 16'(lo) & 16'hFFF0;
				r.version_high = (16'(lo) & 16'hFFF0) | 16'h000F;
			end
		end
		if (r.action == ACT_FIND && tbl_count > 0 && $urandom_range(0, 3) != 0) begin
			p = $urandom_range(0, tbl_count - 1);
			{r.type_code, r.schema_code} = tbl_key[p];
			r.query_version = 16'($urandom_range(tbl_rng[p][31:16], tbl_rng[p][15:0]));
		end
		if (r.action == ACT_READ && $urandom_range(0, 3) != 0)
			r.slot_index = 8'($urandom_range(0, tbl_count > 0 ? tbl_count : 0));
		return r;
	endfunction

	task automatic send(req_t r, logic chk, rsp_t fx);
		rsp_t e;
		@(posedge clk);
		if (!quiet_mode && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 8)) @(posedge clk);
		e = table_apply(r);
		if (chk && e !== fx) begin
			errors++;
			$display("%0t: table row mismatch expected %h actual %h", $time, fx, e);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_rsp.push_back(e);
		req_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction actual %h", $time, rsp);
			end else begin
				if (rsp !== pending_rsp[0]) begin
					errors++;
					$display("%0t: mismatch expected %h actual %h", $time, pending_rsp[0], rsp);
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold)
				rsp_ready <= 1'b0;
			else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_ready <= 1'b1;
			end else
				rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n || long_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("versioned_type_table verification failed");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t w;
		errors = 0;
		tbl_count = 0;
		quiet_mode = 1'b0;
		long_hold = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rows.push_back('{mk(ACT_READ, 0, 0, 0, 0, 0, 0), 1, bare(ST_NOT_FOUND, 0, 0)});
		rows.push_back('{mk(ACT_FIND, 0, 0, 0, 0, 0, 0), 1, bare(ST_NOT_FOUND, 0, 0)});
		rows.push_back('{mk(ACT_ADD, 5, 5, 10, 9, 0, 0), 1, bare(ST_EMPTY, 0, 0)});
		rows.push_back('{mk(ACT_ADD, '1, '1, 0, '1, 0, 0), 1, bare(ST_OK, 0, 1)});
		rows.push_back('{mk(ACT_ADD, '1, '1, 0, '1, 0, 0), 1, bare(ST_DUPLICATE, 0, 1)});
		rows.push_back('{mk(ACT_ADD, '1, '1, 7, 7, 0, 0), 1, bare(ST_OVERLAP, 0, 1)});
		rows.push_back('{mk(ACT_ADD, 0, 0, '1, '1, 0, 0), 1, bare(ST_OK, 0, 2)});
		rows.push_back('{mk(ACT_ADD, 0, 0, 0, 0, 0, 0), 1, bare(ST_OK, 0, 3)});
		rows.push_back('{mk(ACT_ADD, 0, '1, 3, 8, 0, 0), 0, '0});
		rows.push_back('{mk(ACT_ADD, 0, 0, 1, 4, 0, 0), 0, '0});
		rows.push_back('{mk(ACT_ADD, 0, 0, 4, 6, 0, 0), 0, '0});
		rows.push_back('{mk(ACT_FIND, '1, '1, 0, 0, '1, 0), 0, '0});
		rows.push_back('{mk(ACT_FIND, 0, 0, 0, 0, 3, 0), 0, '0});
		rows.push_back('{mk(ACT_FIND, 0, '1, 0, 0, 9, 0), 0, '0});
		rows.push_back('{mk(ACT_READ, 0, 0, 0, 0, 0, 1), 0, '0});
		rows.push_back('{mk(ACT_READ, '1, '1, '1, '1, '1, '1), 1, bare(ST_NOT_FOUND, 0, 5)});
		rows.push_back('{mk(ACT_CLEAR, '1, '1, '1, '1, '1, '1), 1, bare(ST_OK, 0, 0)});
		rows.push_back('{mk(ACT_READ, 0, 0, 0, 0, 0, 0), 1, bare(ST_NOT_FOUND, 0, 0)});
		@(posedge arst_n);
		@(posedge clk);
		foreach (rows[i]) begin
			w = rows[i];
			send(w.r, w.check_fixed, w.fixed);
		end
		drain();
		// Fill to capacity so the full refusal and long shifts are exercised.
		while (tbl_count < CAP)
			send(rand_req(1), 1'b0, '0);
		send(mk(ACT_ADD, 32'hFFFF_0000, 0, 1, 1, 0, 0), 1'b1, bare(ST_FULL, 0, 9'd256));
		send(mk(ACT_READ, 0, 0, 0, 0, 0, 8'd255), 1'b0, '0);
		long_hold = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				long_hold = 1'b0;
			end
			repeat (6) send(rand_req(0), 1'b0, '0);
		join
		drain();
		send(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 150)
				quiet_mode = 1'b1;
			if (n % 400 == 399)
				send(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
			else
				send(rand_req(0), 1'b0, '0);
		end
		drain();
		repeat (1000) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("versioned_type_table verification clean");
		else
			$display("versioned_type_table verification failed");
		$finish;
	end
endmodule
